// File: hdl/sfsd_pkg.sv
package sfsd_pkg;

	// link framing bytes
	localparam logic [7:0] START_BYTE  = 8'h01;
	localparam logic [7:0] ESC_BYTE    = 8'h1B;
	localparam logic [7:0] LOW7_MASK   = 8'h7F;
	localparam logic [7:0] BUTTON_MASK = 8'h7E;
	localparam logic [7:0] ENC_SW_MASK = 8'h20;

	// bytes of the status block that feed the decode
	localparam int DECODE_BYTES = 22;
	localparam int NUM_CHANNELS = 8;
	localparam int QUEUE_DEPTH  = 2;

	// payload byte positions
	localparam int POS_BUTTONS  = 0;
	localparam int POS_TRIMS    = 1;
	localparam int POS_SWITCHES = 2;
	localparam int POS_ANALOG   = 3;
	localparam int POS_ENC_SW   = 19;
	localparam int POS_ENCODER  = 20;
	localparam int POS_REVISION = 21;

	// configuration register indexes
	localparam logic CFG_STATUS_TYPE = 1'b0;
	localparam logic CFG_STATUS_LEN  = 1'b1;

	localparam logic [7:0] STATUS_TYPE_RST = 8'h80;
	localparam logic [6:0] STATUS_LEN_RST  = 7'd22;

	typedef enum logic [1:0] {
		PH_WAIT_START,
		PH_WAIT_TYPE,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic                          frame_ok;
		logic [15:0]                   length_errors;
		logic [DECODE_BYTES-1:0][7:0]  payload;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} push_t;

endpackage

// File: hdl/sfsd_in_if.sv
interface sfsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sfsd_out_if.sv
interface sfsd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel;
	logic [15:0] analog_value;
	logic [6:0]  buttons;
	logic [7:0]  trims;
	logic [9:0]  switch_bits;
	logic [7:0]  encoder_position;
	logic [7:0]  revision;
	logic        frame_ok;
	logic [15:0] length_errors;
	logic        last;

	modport source (
		output valid, output channel, output analog_value, output buttons,
		output trims, output switch_bits, output encoder_position,
		output revision, output frame_ok, output length_errors, output last,
		input ready
	);
	modport sink (
		input valid, input channel, input analog_value, input buttons,
		input trims, input switch_bits, input encoder_position,
		input revision, input frame_ok, input length_errors, input last,
		output ready
	);
endinterface

// File: hdl/sfsd_front.sv
module sfsd_front import sfsd_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	sfsd_in_if.sink    in_ch,
	input  logic       queue_full,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output push_t      push
);

	localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
	localparam int IDX_W = $clog2(DECODE_BYTES);
	localparam int CMP_W = 8;

	phase_t                       phase_q, phase_d;
	logic                         esc_q, esc_d;
	logic [7:0]                   kind_q, kind_d;
	logic [CNT_W-1:0]             count_q, count_d;
	logic [15:0]                  err_q, err_d;
	logic [7:0]                   type_q;
	logic [6:0]                   len_q;
	logic [DECODE_BYTES-1:0][7:0] store_q;

	logic       accept, is_start, is_esc, frame_end, store_we;
	logic [7:0] byte_plain;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_start    = in_ch.rx_byte == START_BYTE;
	assign is_esc      = in_ch.rx_byte == ESC_BYTE;
	assign byte_plain  = esc_q ? (in_ch.rx_byte & LOW7_MASK) : in_ch.rx_byte;

	always_comb begin
		phase_d   = phase_q;
		esc_d     = esc_q;
		kind_d    = kind_q;
		count_d   = count_q;
		err_d     = err_q;
		store_we  = 1'b0;
		frame_end = 1'b0;
		push.valid              = 1'b0;
		push.rec.frame_ok       = 1'b0;
		push.rec.length_errors  = err_q;
		push.rec.payload        = store_q;
		if (accept) begin
			unique case (phase_q)
				PH_WAIT_START: begin
					if (is_start) begin
						phase_d = PH_WAIT_TYPE;
					end
				end
				PH_WAIT_TYPE: begin
					if (!is_start) begin
						if (is_esc) begin
							esc_d = 1'b1;
						end else begin
							kind_d  = byte_plain;
							esc_d   = 1'b0;
							count_d = '0;
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					priority if (is_start) begin
						phase_d   = PH_WAIT_START;
						frame_end = 1'b1;
					end else if (is_esc) begin
						esc_d = 1'b1;
					end else begin
						esc_d = 1'b0;
						if (count_q < CNT_W'(PAYLOAD_DEPTH)) begin
							count_d  = count_q + 1'b1;
							store_we = count_q < CNT_W'(DECODE_BYTES);
						end
					end
				end
				default: phase_d = PH_WAIT_START;
			endcase
		end
		if (frame_end && kind_q == type_q) begin
			push.valid = 1'b1;
			if (CMP_W'(count_q) != CMP_W'(len_q)) begin
				err_d                  = err_q + 16'd1;
				push.rec.length_errors = err_d;
			end else begin
				push.rec.frame_ok = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_START;
			esc_q   <= 1'b0;
			kind_q  <= '0;
			count_q <= '0;
			err_q   <= '0;
		end else begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			kind_q  <= kind_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= STATUS_TYPE_RST;
			len_q  <= STATUS_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STATUS_TYPE: type_q <= cfg_data;
				CFG_STATUS_LEN:  len_q  <= cfg_data[6:0];
			endcase
		end
	end

	// only the decoded head of the payload is kept
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[count_q[IDX_W-1:0]] <= byte_plain;
		end
	end

endmodule

// File: hdl/sfsd_queue.sv
module sfsd_queue import sfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output frame_rec_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_rec_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.rec;
		end
	end

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full && !pop))
		else $error("queue written while full");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");
`endif

endmodule

// File: hdl/sfsd_back.sv
module sfsd_back import sfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  frame_rec_t head,
	output logic       pop,
	sfsd_out_if.source out_ch
);

	localparam int CH_W  = $clog2(NUM_CHANNELS);
	localparam int IDX_W = $clog2(DECODE_BYTES);

	logic [CH_W-1:0]  ch_q;
	logic             valid_q;
	logic [2:0]       channel_q;
	logic [15:0]      analog_q;
	logic [6:0]       buttons_q;
	logic [7:0]       trims_q;
	logic [9:0]       switch_q;
	logic [7:0]       encoder_q;
	logic [7:0]       revision_q;
	logic             ok_q;
	logic [15:0]      errors_q;
	logic             last_q;

	logic             load, last_d;
	logic [IDX_W-1:0] lo_idx;
	logic [15:0]      analog_d;
	logic [9:0]       switch_d;
	logic [7:0]       b0;

	assign load   = head_valid && (!valid_q || out_ch.ready);
	assign last_d = !head.frame_ok || ch_q == CH_W'(NUM_CHANNELS - 1);
	assign pop    = load && last_d;

	// two bytes per channel, little-endian
	assign lo_idx   = IDX_W'(POS_ANALOG) + IDX_W'({ch_q, 1'b0});
	assign analog_d = {head.payload[lo_idx + 1'b1], head.payload[lo_idx]};
	assign b0       = head.payload[POS_BUTTONS];
	assign switch_d = {|(head.payload[POS_ENC_SW] & ENC_SW_MASK), b0[0],
		head.payload[POS_SWITCHES]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				ch_q    <= last_d ? '0 : ch_q + 1'b1;
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q     <= head.frame_ok;
			errors_q <= head.length_errors;
			last_q   <= last_d;
			if (head.frame_ok) begin
				channel_q  <= 3'(ch_q);
				analog_q   <= analog_d;
				buttons_q  <= 7'(b0 & BUTTON_MASK);
				trims_q    <= head.payload[POS_TRIMS];
				switch_q   <= switch_d;
				encoder_q  <= head.payload[POS_ENCODER];
				revision_q <= head.payload[POS_REVISION];
			end else begin
				channel_q  <= '0;
				analog_q   <= '0;
				buttons_q  <= '0;
				trims_q    <= '0;
				switch_q   <= '0;
				encoder_q  <= '0;
				revision_q <= '0;
			end
		end
	end

	assign out_ch.valid            = valid_q;
	assign out_ch.channel          = channel_q;
	assign out_ch.analog_value     = analog_q;
	assign out_ch.buttons          = buttons_q;
	assign out_ch.trims            = trims_q;
	assign out_ch.switch_bits      = switch_q;
	assign out_ch.encoder_position = encoder_q;
	assign out_ch.revision         = revision_q;
	assign out_ch.frame_ok         = ok_q;
	assign out_ch.length_errors    = errors_q;
	assign out_ch.last             = last_q;

`ifndef SYNTHESIS
	a_burst_on_good_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q != '0 |-> head_valid && head.frame_ok)
		else $error("channel counter running without a good frame");
	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.frame_ok |-> out_ch.last && out_ch.channel == 3'd0
		&& out_ch.analog_value == 16'd0)
		else $error("length error result malformed");
	a_good_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.frame_ok && out_ch.last |-> out_ch.channel == 3'd7)
		else $error("status burst ended early");
`endif

endmodule

// File: hdl/stuffed_frame_status_decoder.sv
// Deframes byte-stuffed link traffic (0x01, type, payload, 0x01, with 0x1B
// clearing bit 7 of the next byte) and turns each status frame into a burst of
// eight channel results, or a single length-error result when the payload
// length is wrong; other frame types are silently consumed. The receive side
// takes one byte per clock; its ready only drops while the two-entry frame
// queue between the deframer and the result sequencer is full. A good status
// frame gives eight result transactions, an error frame one; the sequencer
// paces back-to-back frames at one result transaction per cycle while ready.
// Users must write configuration only with no frame in flight; not enforced.
module stuffed_frame_status_decoder import sfsd_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	sfsd_in_if.sink    in_ch,
	sfsd_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// frame record handed from deframer to sequencer
	push_t      push;
	logic       queue_full;
	logic       pop;
	logic       head_valid;
	frame_rec_t head;

	// front: unstuffing, payload capture, length check and error count
	sfsd_front #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.queue_full (queue_full),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push)
	);

	// short decoupling queue of finished frames
	sfsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: one result transaction per cycle from the queue head while out_ch is ready
	sfsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule
